### design/uvt_pkg.sv
`default_nettype none

package uvt_pkg;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic       full_drop;
      logic [6:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_RD_LAST,
      ST_MOVE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic add;
      logic scan;
      logic rd_last;
      logic wr_move;
      logic clear;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic match;
      logic scan_done;
      logic clear_done;
   } dp_stat_type;

endpackage

`default_nettype wire

### design/uvt_ctrl.sv
`default_nettype none

module uvt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire uvt_pkg::cmd_type    req_cmd,
   input  wire uvt_pkg::dp_stat_type stat,
   output uvt_pkg::dp_cmd_type      dp_cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   uvt_pkg::state_type state_ff, state_in;
   uvt_pkg::cmd_type   op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uvt_pkg::ST_IDLE;
         op_ff    <= uvt_pkg::CMD_ADD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         uvt_pkg::ST_IDLE: begin
            if (start) begin
               op_in = req_cmd;
               case (req_cmd)
                  uvt_pkg::CMD_ADD:      state_in = uvt_pkg::ST_ADD;
                  uvt_pkg::CMD_REMOVE:   state_in = uvt_pkg::ST_SCAN;
                  uvt_pkg::CMD_CONTAINS: state_in = uvt_pkg::ST_SCAN;
                  uvt_pkg::CMD_CLEAR:    state_in = uvt_pkg::ST_CLEAR;
                  default:               state_in = uvt_pkg::ST_IDLE;
               endcase
            end
         end
         uvt_pkg::ST_ADD: state_in = uvt_pkg::ST_RESP;
         uvt_pkg::ST_SCAN: begin
            if (stat.match) begin
               state_in = (op_ff == uvt_pkg::CMD_REMOVE) ? uvt_pkg::ST_RD_LAST
                                                         : uvt_pkg::ST_RESP;
            end else if (stat.scan_done) begin
               state_in = uvt_pkg::ST_RESP;
            end
         end
         uvt_pkg::ST_RD_LAST: state_in = uvt_pkg::ST_MOVE;
         uvt_pkg::ST_MOVE:    state_in = uvt_pkg::ST_RESP;
         uvt_pkg::ST_CLEAR: begin
            if (stat.clear_done) begin
               state_in = uvt_pkg::ST_RESP;
            end
         end
         uvt_pkg::ST_RESP: state_in = uvt_pkg::ST_IDLE;
         default:          state_in = uvt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd    = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         uvt_pkg::ST_IDLE: begin
            busy        = 1'b0;
            dp_cmd.load = start;
         end
         uvt_pkg::ST_ADD:     dp_cmd.add     = 1'b1;
         uvt_pkg::ST_SCAN:    dp_cmd.scan    = 1'b1;
         uvt_pkg::ST_RD_LAST: dp_cmd.rd_last = 1'b1;
         uvt_pkg::ST_MOVE:    dp_cmd.wr_move = 1'b1;
         uvt_pkg::ST_CLEAR:   dp_cmd.clear   = 1'b1;
         uvt_pkg::ST_RESP:    rsp_valid      = 1'b1;
         default:             busy           = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

### design/uvt_dp.sv
`default_nettype none

module uvt_dp #(
   parameter int CAPACITY = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [31:0]           value,
   input  wire uvt_pkg::dp_cmd_type          cmd,
   output uvt_pkg::dp_stat_type              stat,
   output logic                              hit,
   output logic                              full_drop,
   output logic [$clog2(CAPACITY + 1) - 1:0] count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic [31:0]   mem [CAPACITY];
   logic [31:0]   rdata_ff;

   logic [31:0]   value_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic [CW-1:0] last_idx;
   logic          cmp_vld_ff, cmp_vld_in;
   logic          hit_ff, hit_in;
   logic          drop_ff, drop_in;

   logic          full;
   logic          ptr_below;
   logic          match;
   logic          issue;
   logic          we, re;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wdata;

   assign full      = (count_ff == CW'(CAPACITY));
   assign ptr_below = (ptr_ff < count_ff);
   assign match     = cmp_vld_ff && (rdata_ff == value_ff);
   // stop reading once a match shows, so cmp_ptr_ff keeps its position
   assign issue     = cmd.scan && ptr_below && !match;
   assign last_idx  = count_ff - CW'(1);

   always_comb begin
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      hit_in     = hit_ff;
      drop_in    = drop_ff;
      cmp_vld_in = issue;
      cmp_ptr_in = issue ? ptr_ff : cmp_ptr_ff;
      if (cmd.load) begin
         ptr_in  = '0;
         hit_in  = 1'b0;
         drop_in = 1'b0;
      end
      if (cmd.add) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
            hit_in   = 1'b1;
         end
      end
      if (cmd.scan) begin
         if (match) begin
            hit_in = 1'b1;
         end
         if (issue) begin
            ptr_in = ptr_ff + CW'(1);
         end
      end
      if (cmd.wr_move) begin
         count_in = last_idx;
      end
      if (cmd.clear && ptr_below) begin
         ptr_in = ptr_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ptr_ff <= cmp_ptr_in;
      hit_ff     <= hit_in;
      drop_ff    <= drop_in;
      if (cmd.load) begin
         value_ff <= value;
      end
   end

   // table write port: append, move last entry into the hole, or zero fill
   always_comb begin
      we      = (cmd.add && !full) || cmd.wr_move || (cmd.clear && ptr_below);
      wr_addr = ptr_ff[AW-1:0];
      wdata   = '0;
      if (cmd.add) begin
         wr_addr = count_ff[AW-1:0];
         wdata   = value_ff;
      end else if (cmd.wr_move) begin
         wr_addr = cmp_ptr_ff[AW-1:0];
         wdata   = rdata_ff;
      end
   end

   assign re      = issue || cmd.rd_last;
   assign rd_addr = cmd.rd_last ? last_idx[AW-1:0] : ptr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign stat.match      = match;
   assign stat.scan_done  = !ptr_below && !cmp_vld_ff;
   assign stat.clear_done = !ptr_below;

   assign hit       = hit_ff;
   assign full_drop = drop_ff;
   assign count     = count_ff;

endmodule

`default_nettype wire

### design/unsorted_value_table.sv
`default_nettype none

// Unordered table of up to CAPACITY signed 32-bit values with swap-remove.
// An item is taken when start is high and busy is low; busy stays high until
// the item's single result has been shown. The result appears on rsp_item for
// exactly one cycle, flagged by rsp_valid, and must be taken then: there is no
// way to hold it off. Contains and remove scan the occupied entries and stop at
// the first match; a remove that finds a match then reads the last entry and
// moves it into the hole. The scans walk the table memory one entry per cycle on
// its single read port, and clear writes one entry per cycle. The table
// contents are not cleared by reset; only occupied entries are ever read.
module unsorted_value_table #(
   parameter int CAPACITY = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire uvt_pkg::req_type req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output uvt_pkg::rsp_type      rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);

   uvt_pkg::dp_cmd_type  dp_cmd;
   uvt_pkg::dp_stat_type dp_stat;
   logic                 hit;
   logic                 full_drop;
   logic [CW-1:0]        count;

   uvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_item.cmd),
      .stat      (dp_stat),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   uvt_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .value     (req_item.value),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .hit       (hit),
      .full_drop (full_drop),
      .count     (count)
   );

   assign rsp_item.hit         = hit;
   assign rsp_item.full_drop   = full_drop;
   assign rsp_item.entry_count = 7'(count);

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown with no item in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("more than one result for an item");

   a_drop_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.full_drop |-> !rsp_item.hit)
      else $error("dropped add reported as stored");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.full_drop |-> rsp_item.entry_count == 7'(CAPACITY))
      else $error("add dropped while table not full");
`endif

endmodule

`default_nettype wire

### tb/unsorted_value_table_tb.sv
`timescale 1ns / 100ps

module unsorted_value_table_tb;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 2 * CAPACITY + 16;

   typedef enum int {
      PH_MIX,
      PH_FILL,
      PH_DRAIN
   } phase_type;

   typedef struct {
      uvt_pkg::cmd_type cmd;
      logic [31:0]      value;
      bit               fixed;
      uvt_pkg::rsp_type rsp;
   } script_row_type;

   logic             clock;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   uvt_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_valid;
   uvt_pkg::rsp_type rsp_item;

   // typed-in expectation that travels with the item on req_item
   bit               pin_fixed = 1'b0;
   uvt_pkg::rsp_type pin_rsp   = '0;

   // shadow copy of the table
   logic [31:0] tbl_vals [CAPACITY];
   int          tbl_count = 0;

   uvt_pkg::rsp_type pending_rsp[$];
   script_row_type   script[$];
   logic [31:0]      val_pool [6];

   uvt_pkg::rsp_type predicted;
   uvt_pkg::rsp_type want;
   int      cycle_count   = 0;
   int      error_count   = 0;
   int      results_seen  = 0;
   int      cmd_seen [4]  = '{0, 0, 0, 0};
   int      drops_seen    = 0;
   int      finds_seen    = 0;

   unsorted_value_table #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_rsp.size());
         $display("simulation failed");
         $finish;
      end
   end

   // apply one command to the shadow table and return its result
   function automatic uvt_pkg::rsp_type apply_command(uvt_pkg::req_type item);
      uvt_pkg::rsp_type r;
      int               pos;
      r   = '0;
      pos = -1;
      case (item.cmd)
         uvt_pkg::CMD_ADD: begin
            if (tbl_count < CAPACITY) begin
               tbl_vals[tbl_count] = item.value;
               tbl_count++;
               r.hit = 1'b1;
            end else begin
               r.full_drop = 1'b1;
            end
         end
         uvt_pkg::CMD_REMOVE, uvt_pkg::CMD_CONTAINS: begin
            for (int k = 0; k < tbl_count; k++)
               if (pos < 0 && tbl_vals[k] == item.value)
                  pos = k;
            if (pos >= 0) begin
               r.hit = 1'b1;
               if (item.cmd == uvt_pkg::CMD_REMOVE) begin
                  tbl_vals[pos] = tbl_vals[tbl_count - 1];
                  tbl_count--;
               end
            end
         end
         default: begin
            for (int k = 0; k < tbl_count; k++)
               tbl_vals[k] = '0;
         end
      endcase
      r.entry_count = 7'(tbl_count);
      return r;
   endfunction

   // check results and record accepted items in one process, so the order is fixed
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
               $error("result with no item outstanding: %p", rsp_item);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_item.hit !== want.hit) begin
                  $error("hit: expected %0b, actual %0b", want.hit, rsp_item.hit);
                  error_count++;
               end
               if (rsp_item.full_drop !== want.full_drop) begin
                  $error("full_drop: expected %0b, actual %0b", want.full_drop,
                         rsp_item.full_drop);
                  error_count++;
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d", want.entry_count,
                         rsp_item.entry_count);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            predicted = apply_command(req_item);
            cmd_seen[req_item.cmd]++;
            if (predicted.full_drop)
               drops_seen++;
            if (predicted.hit && req_item.cmd != uvt_pkg::CMD_ADD)
               finds_seen++;
            pending_rsp.push_back(pin_fixed ? pin_rsp : predicted);
         end
      end
   end

   task automatic add_row(uvt_pkg::cmd_type c, logic [31:0] v, bit fixed, bit h,
                          bit d, int n);
      script_row_type row;
      row.cmd             = c;
      row.value           = v;
      row.fixed           = fixed;
      row.rsp.hit         = h;
      row.rsp.full_drop   = d;
      row.rsp.entry_count = 7'(n);
      script.push_back(row);
   endtask

   // present one item and hold it until taken; optionally idle afterwards
   task automatic send_item(uvt_pkg::cmd_type c, logic [31:0] v, bit fixed,
                            uvt_pkg::rsp_type r, bit idle_on);
      uvt_pkg::req_type item;
      item.cmd   = c;
      item.value = v;
      start     <= 1'b1;
      req_item  <= item;
      pin_fixed <= fixed;
      pin_rsp   <= r;
      do @(posedge clock); while (busy);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         return val_pool[$urandom_range(0, 5)];
      if (sel < 85)
         case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
         endcase
      return $urandom;
   endfunction

   function automatic uvt_pkg::cmd_type pick_cmd(phase_type kind);
      int sel;
      sel = $urandom_range(0, 99);
      case (kind)
         PH_FILL:  return uvt_pkg::CMD_ADD;
         PH_DRAIN: return (sel < 80) ? uvt_pkg::CMD_REMOVE : uvt_pkg::CMD_CONTAINS;
         default: begin
            if (sel < 35)
               return uvt_pkg::CMD_ADD;
            if (sel < 65)
               return uvt_pkg::CMD_REMOVE;
            if (sel < 90)
               return uvt_pkg::CMD_CONTAINS;
            return uvt_pkg::CMD_CLEAR;
         end
      endcase
   endfunction

   task automatic run_phase(phase_type kind, int count, bit idle_on);
      if (kind == PH_MIX)
         foreach (val_pool[i])
            val_pool[i] = $urandom;
      repeat (count)
         send_item(pick_cmd(kind), pick_value(), 1'b0, '0, idle_on);
   endtask

   initial begin
      foreach (val_pool[i])
         val_pool[i] = $urandom;

      // empty table, extremes, duplicates, remove of the last entry, clear
      add_row(uvt_pkg::CMD_CONTAINS, 32'h0000_0000, 1, 0, 0, 0);
      add_row(uvt_pkg::CMD_REMOVE,   32'h0000_0000, 1, 0, 0, 0);
      add_row(uvt_pkg::CMD_CLEAR,    32'h1234_5678, 1, 0, 0, 0);
      add_row(uvt_pkg::CMD_ADD,      32'h7FFF_FFFF, 1, 1, 0, 1);
      add_row(uvt_pkg::CMD_ADD,      32'h8000_0000, 1, 1, 0, 2);
      add_row(uvt_pkg::CMD_ADD,      32'h0000_0000, 1, 1, 0, 3);
      add_row(uvt_pkg::CMD_ADD,      32'hFFFF_FFFF, 1, 1, 0, 4);
      add_row(uvt_pkg::CMD_ADD,      32'h8000_0000, 1, 1, 0, 5);
      add_row(uvt_pkg::CMD_CONTAINS, 32'h8000_0000, 1, 1, 0, 5);
      add_row(uvt_pkg::CMD_CONTAINS, 32'h7FFF_FFFE, 1, 0, 0, 5);
      add_row(uvt_pkg::CMD_REMOVE,   32'h8000_0000, 1, 1, 0, 4);
      add_row(uvt_pkg::CMD_CONTAINS, 32'h8000_0000, 1, 1, 0, 4);
      add_row(uvt_pkg::CMD_REMOVE,   32'hFFFF_FFFF, 1, 1, 0, 3);
      add_row(uvt_pkg::CMD_REMOVE,   32'h0001_2345, 1, 0, 0, 3);
      add_row(uvt_pkg::CMD_CLEAR,    32'hFFFF_FFFF, 1, 0, 0, 3);
      add_row(uvt_pkg::CMD_CONTAINS, 32'h0000_0000, 1, 1, 0, 3);
      add_row(uvt_pkg::CMD_CONTAINS, 32'h7FFF_FFFF, 1, 0, 0, 3);
      add_row(uvt_pkg::CMD_REMOVE,   32'h0000_0000, 1, 1, 0, 2);
      add_row(uvt_pkg::CMD_REMOVE,   32'h0000_0000, 1, 1, 0, 1);
      add_row(uvt_pkg::CMD_REMOVE,   32'h0000_0000, 1, 1, 0, 0);
      add_row(uvt_pkg::CMD_REMOVE,   32'h0000_0000, 1, 0, 0, 0);
      add_row(uvt_pkg::CMD_ADD,      32'h55AA_55AA, 1, 1, 0, 1);
      add_row(uvt_pkg::CMD_ADD,      32'hAAAA_AAAA, 0, 0, 0, 0);
      add_row(uvt_pkg::CMD_CONTAINS, 32'h55AA_55AA, 0, 0, 0, 0);
      add_row(uvt_pkg::CMD_REMOVE,   32'hAAAA_AAAA, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_item(script[i].cmd, script[i].value, script[i].fixed, script[i].rsp, 1'b1);

      // fill phases overrun capacity, so adds to a full table come up
      run_phase(PH_MIX,   50, 1'b1);
      run_phase(PH_FILL,  70, 1'b1);
      wait_drained();
      run_phase(PH_DRAIN, 70, 1'b1);
      run_phase(PH_MIX,   50, 1'b0);
      run_phase(PH_FILL,  70, 1'b1);
      run_phase(PH_DRAIN, 40, 1'b1);
      run_phase(PH_MIX,   50, 1'b0);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d results never arrived", pending_rsp.size());
         error_count++;
      end

      $display("%0d items in: %0d add, %0d remove, %0d contains, %0d clear; %0d results",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
               cmd_seen[uvt_pkg::CMD_ADD], cmd_seen[uvt_pkg::CMD_REMOVE],
               cmd_seen[uvt_pkg::CMD_CONTAINS], cmd_seen[uvt_pkg::CMD_CLEAR],
               results_seen);
      $display("%0d adds refused on a full table, %0d removes or lookups found a match",
               drops_seen, finds_seen);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
